### rtl/core/eqsd_pkg.sv
package eqsd_pkg;

  localparam int DEF_QUEUE_DEPTH      = 4;
  localparam int DEF_SUBSCRIBER_SLOTS = 8;
  localparam int NUM_REGS             = 8;
  localparam int REG_IDX_W            = 3;
  localparam int CFG_IDX_W            = 4;
  localparam int SUB_MATCH_W          = 9;
  localparam int ID_W                 = 8;
  localparam int DATA_W               = 8;
  localparam int SUB_W                = 3;
  localparam int COUNT_W              = 6;
  localparam int PENDING_W            = 3;

  typedef enum logic {
    OP_PUBLISH  = 1'b0,
    OP_DISPATCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS   = 2'd0,
    KIND_DELIVERY = 2'd1,
    KIND_DONE     = 2'd2
  } kind_e;

  typedef struct packed {
    logic              command;
    logic [ID_W-1:0]   evt_id;
    logic [DATA_W-1:0] payload;
  } eqsd_in_t;

  typedef struct packed {
    kind_e                kind;
    logic                 accepted;
    logic [SUB_W-1:0]     subscriber;
    logic [ID_W-1:0]      delivered_id;
    logic [DATA_W-1:0]    delivered_data;
    logic [COUNT_W-1:0]   delivered_count;
    logic [PENDING_W-1:0] pending;
    logic                 last;
  } eqsd_out_t;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   evt_id;
    logic [DATA_W-1:0] payload;
  } eqsd_cmd_t;

endpackage

### rtl/core/eqsd_front.sv
module eqsd_front
  import eqsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  eqsd_in_t  in_data_i,
  output logic      cmd_valid_o,
  output eqsd_cmd_t cmd_o,
  input  logic      cmd_pop_i
);

  eqsd_cmd_t  fifo_q [2];
  eqsd_cmd_t  new_cmd;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;

  // decode the command into an operation
  always_comb begin
    new_cmd.op      = in_data_i.command ? OP_DISPATCH : OP_PUBLISH;
    new_cmd.evt_id  = in_data_i.evt_id;
    new_cmd.payload = in_data_i.payload;
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/core/eqsd_back.sv
module eqsd_back
  import eqsd_pkg::*;
#(
  parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH,
  parameter int SUBSCRIBER_SLOTS = DEF_SUBSCRIBER_SLOTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  input  eqsd_cmd_t                    cmd_i,
  output logic                         cmd_pop_o,
  input  logic [NUM_REGS-1:0][SUB_MATCH_W-1:0] sub_match_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output eqsd_out_t                    out_data_o
);

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W = (SUBSCRIBER_SLOTS > 1) ? $clog2(SUBSCRIBER_SLOTS) : 1;
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(QUEUE_DEPTH - 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                      state_q, state_d;
  logic [ID_W+DATA_W-1:0]      ring_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]            rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]            wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [SUBSCRIBER_SLOTS-1:0] served_q, served_d;
  logic [COUNT_W-1:0]          delivered_q, delivered_d;
  logic                        out_valid_q, out_valid_d;
  eqsd_out_t                   out_q, out_d;
  logic                        ring_we;
  logic                        out_free;
  logic [ID_W-1:0]             head_id;
  logic [DATA_W-1:0]           head_data;
  logic [SUBSCRIBER_SLOTS-1:0] match;
  logic [SUBSCRIBER_SLOTS-1:0] hit;
  logic [SUBSCRIBER_SLOTS-1:0] rest;
  logic [SLOT_W-1:0]           sel;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PtrLast) ? '0 : p + PTR_W'(1);
  endfunction

  assign head_id   = ring_q[rd_ptr_q][ID_W+DATA_W-1:DATA_W];
  assign head_data = ring_q[rd_ptr_q][DATA_W-1:0];
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int s = 0; s < SUBSCRIBER_SLOTS; s++) begin
      match[s] = sub_match_i[s][SUB_MATCH_W-1] && (sub_match_i[s][ID_W-1:0] == head_id);
    end
  end

  assign hit  = match & served_q;
  assign rest = hit & (hit - SUBSCRIBER_SLOTS'(1));

  // lowest slot still to be served
  always_comb begin
    sel = '0;
    for (int s = SUBSCRIBER_SLOTS - 1; s >= 0; s--) begin
      if (hit[s]) begin
        sel = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    cnt_d       = cnt_q;
    served_d    = served_q;
    delivered_d = delivered_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    ring_we     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == OP_PUBLISH) begin
            if (out_free) begin
              cmd_pop_o   = 1'b1;
              out_valid_d = 1'b1;
              out_d       = '0;
              out_d.kind  = KIND_STATUS;
              out_d.last  = 1'b1;
              if (cnt_q != CntFull) begin
                ring_we        = 1'b1;
                wr_ptr_d       = ptr_next(wr_ptr_q);
                cnt_d          = cnt_q + CNT_W'(1);
                out_d.accepted = 1'b1;
                out_d.pending  = PENDING_W'(cnt_q + CNT_W'(1));
              end else begin
                out_d.pending = PENDING_W'(cnt_q);
              end
            end
          end else begin
            cmd_pop_o   = 1'b1;
            state_d     = ST_SCAN;
            served_d    = '1;
            delivered_d = '0;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_q == '0) begin
          if (out_free) begin
            out_valid_d           = 1'b1;
            out_d                 = '0;
            out_d.kind            = KIND_DONE;
            out_d.delivered_count = delivered_q;
            out_d.last            = 1'b1;
            state_d               = ST_IDLE;
          end
        end else if (hit == '0) begin
          rd_ptr_d = ptr_next(rd_ptr_q);
          cnt_d    = cnt_q - CNT_W'(1);
          served_d = '1;
        end else if (out_free) begin
          out_valid_d          = 1'b1;
          out_d                = '0;
          out_d.kind           = KIND_DELIVERY;
          out_d.subscriber     = SUB_W'(sel);
          out_d.delivered_id   = head_id;
          out_d.delivered_data = head_data;
          out_d.pending        = PENDING_W'(cnt_q - CNT_W'(1));
          delivered_d          = delivered_q + COUNT_W'(1);
          served_d             = served_q & ~(hit & ~rest);
          if (rest == '0) begin
            rd_ptr_d = ptr_next(rd_ptr_q);
            cnt_d    = cnt_q - CNT_W'(1);
            served_d = '1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[wr_ptr_q] <= {cmd_i.evt_id, cmd_i.payload};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      cnt_q       <= '0;
      served_q    <= '1;
      delivered_q <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      cnt_q       <= cnt_d;
      served_q    <= served_d;
      delivered_q <= delivered_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/event_queue_subscriber_dispatch.sv
// publish status and dispatch results are registered, behind the two-entry command FIFO
// publish: one item per cycle sustained while the output is not stalled and no dispatch is running
// dispatch: a start step, a delivery per matching slot, a skip per unmatched queued event, then done
// subscriber matching is one compare per slot against the head of the event ring
// reset: pointers, counts and subscriber registers clear at once; event ring is not cleared
module event_queue_subscriber_dispatch
  import eqsd_pkg::*;
#(
  parameter int QUEUE_DEPTH      = DEF_QUEUE_DEPTH,
  parameter int SUBSCRIBER_SLOTS = DEF_SUBSCRIBER_SLOTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  eqsd_in_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output eqsd_out_t              out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [SUB_MATCH_W-1:0] cfg_data_i
);

  logic [NUM_REGS-1:0][SUB_MATCH_W-1:0] sub_match_q;
  logic                                 cmd_valid;
  eqsd_cmd_t                            cmd;
  logic                                 cmd_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_match_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      sub_match_q[cfg_index_i[REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  eqsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  eqsd_back #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .SUBSCRIBER_SLOTS (SUBSCRIBER_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .sub_match_i (sub_match_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/eqsd_checker.sv
module eqsd_checker
  import eqsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input eqsd_out_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result beat changed");

  a_delivery_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind == KIND_DELIVERY |->
      !out_data_i.last && out_data_i.delivered_count == '0)
    else $error("delivery beat marked last or carries a count");

  a_status_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.kind == KIND_STATUS |->
      out_data_i.last && (out_data_i.pending != '0 || !out_data_i.accepted))
    else $error("publish status inconsistent");

  a_pending_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.pending <= PENDING_W'(QUEUE_DEPTH))
    else $error("pending count exceeds queue depth");

endmodule

bind event_queue_subscriber_dispatch eqsd_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_eqsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import eqsd_pkg::*;

  localparam int DEPTH       = DEF_QUEUE_DEPTH;
  localparam int SLOTS       = DEF_SUBSCRIBER_SLOTS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 40;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  eqsd_in_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  eqsd_out_t              out_data_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [SUB_MATCH_W-1:0] cfg_data_i  = '0;

  event_queue_subscriber_dispatch i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mirror of the block state
  logic [SUB_MATCH_W-1:0] sub_reg [NUM_REGS];
  logic [15:0]            ring    [DEPTH];
  int                     rd_ptr   = 0;
  int                     wr_ptr   = 0;
  int                     ring_cnt = 0;

  eqsd_out_t              owed_beats [$];
  int                     err_cnt  = 0;
  bit                     idle_on  = 1'b1;
  int                     hold_len = 0;
  logic [SUB_MATCH_W-1:0] slot_plan [NUM_REGS];
  logic [ID_W-1:0]        hot_ids [4];

  initial begin
    for (int s = 0; s < NUM_REGS; s++) sub_reg[s] = '0;
  end

  function automatic void run_bus_command(eqsd_in_t item);
    eqsd_out_t   beat;
    int unsigned hits;
    logic [15:0] head;
    beat = '0;
    if (item.command == OP_PUBLISH) begin
      beat.kind = KIND_STATUS;
      if (ring_cnt < DEPTH) begin
        ring[wr_ptr]  = {item.evt_id, item.payload};
        wr_ptr        = (wr_ptr + 1) % DEPTH;
        ring_cnt      = ring_cnt + 1;
        beat.accepted = 1'b1;
      end
      beat.pending = PENDING_W'(ring_cnt);
      beat.last    = 1'b1;
      owed_beats.push_back(beat);
    end else begin
      hits = 0;
      while (ring_cnt > 0) begin
        head     = ring[rd_ptr];
        rd_ptr   = (rd_ptr + 1) % DEPTH;
        ring_cnt = ring_cnt - 1;
        for (int s = 0; s < SLOTS && s < NUM_REGS; s++) begin
          if (sub_reg[s][8] && sub_reg[s][7:0] == head[15:8]) begin
            beat                = '0;
            beat.kind           = KIND_DELIVERY;
            beat.subscriber     = SUB_W'(s);
            beat.delivered_id   = head[15:8];
            beat.delivered_data = head[7:0];
            beat.pending        = PENDING_W'(ring_cnt);
            owed_beats.push_back(beat);
            hits++;
          end
        end
      end
      beat                 = '0;
      beat.kind            = KIND_DONE;
      beat.delivered_count = COUNT_W'(hits);
      beat.pending         = PENDING_W'(ring_cnt);
      beat.last            = 1'b1;
      owed_beats.push_back(beat);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) run_bus_command(in_data_i);
    if (rst_ni && cfg_valid_i && cfg_ready_o && cfg_index_i < NUM_REGS) begin
      sub_reg[cfg_index_i[REG_IDX_W-1:0]] = cfg_data_i;
    end
  end

  function automatic void note_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : beat_checker
    eqsd_out_t want;
    eqsd_out_t got;
    got = out_data_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_beats.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t unexpected beat: expected none, actual kind %0d", $time, got.kind);
      end else begin
        want = owed_beats.pop_front();
        note_field("kind", want.kind, got.kind);
        note_field("accepted", want.accepted, got.accepted);
        note_field("subscriber", want.subscriber, got.subscriber);
        note_field("delivered_id", want.delivered_id, got.delivered_id);
        note_field("delivered_data", want.delivered_data, got.delivered_data);
        note_field("delivered_count", want.delivered_count, got.delivered_count);
        note_field("pending", want.pending, got.pending);
        note_field("last", want.last, got.last);
      end
    end
  end

  initial begin : rx_side
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        gap      = hold_len;
        hold_len = 0;
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic eqsd_in_t pub_item(logic [ID_W-1:0] id, logic [DATA_W-1:0] data);
    eqsd_in_t it;
    it.command = OP_PUBLISH;
    it.evt_id  = id;
    it.payload = data;
    return it;
  endfunction

  // id and payload are don't-care on dispatch, so they carry noise
  function automatic eqsd_in_t disp_item();
    eqsd_in_t it;
    it.command = OP_DISPATCH;
    it.evt_id  = ID_W'($urandom);
    it.payload = DATA_W'($urandom);
    return it;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 4) != 0) return hot_ids[$urandom_range(0, 3)];
    return ID_W'($urandom);
  endfunction

  task automatic send_item(input eqsd_in_t item);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results(input int pad);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (owed_beats.size() != 0);
    repeat (pad) @(posedge clk_i);
  endtask

  task automatic cfg_write(input int idx, input logic [SUB_MATCH_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_IDX_W'(idx);
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // all slots, then one write past the register list that must be dropped
  task automatic load_slots();
    for (int s = 0; s < NUM_REGS; s++) cfg_write(s, slot_plan[s]);
    cfg_write($urandom_range(NUM_REGS, 2**CFG_IDX_W - 1), SUB_MATCH_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic plan_random_slots();
    for (int h = 0; h < 4; h++) hot_ids[h] = ID_W'($urandom);
    for (int s = 0; s < NUM_REGS; s++)
      slot_plan[s] = {($urandom_range(0, 3) != 0), hot_ids[$urandom_range(0, 3)]};
  endtask

  // mostly publish bursts closed by a dispatch, some loose noise items
  task automatic run_traffic(input int n_items);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) send_item(pub_item(ID_W'($urandom), DATA_W'($urandom)));
        else send_item(disp_item());
        sent++;
      end else begin
        burst = $urandom_range(0, 6);
        repeat (burst) begin
          send_item(pub_item(pick_id(), DATA_W'($urandom)));
          sent++;
        end
        send_item(disp_item());
        sent++;
      end
    end
  endtask

  task automatic test_empty_queue_no_subscribers();
    drain_results(6);
    for (int s = 0; s < NUM_REGS; s++) slot_plan[s] = '0;
    load_slots();
    send_item(disp_item());
    send_item(pub_item(8'h00, 8'h00));
    send_item(pub_item(8'hFF, 8'hFF));
    send_item(disp_item());
  endtask

  task automatic test_fanout_and_full_queue();
    drain_results(6);
    for (int s = 0; s < NUM_REGS; s++) slot_plan[s] = 9'h1FF;
    load_slots();
    send_item(pub_item(8'hFF, 8'hAA));
    send_item(pub_item(8'hFF, 8'h55));
    send_item(pub_item(8'hFF, 8'h00));
    send_item(pub_item(8'hFF, 8'hFF));
    send_item(pub_item(8'hFF, 8'h11));
    send_item(disp_item());
  endtask

  task automatic test_mixed_slots();
    drain_results(6);
    slot_plan[0] = 9'h100;
    slot_plan[1] = 9'h000;
    slot_plan[2] = 9'h100;
    slot_plan[3] = 9'h17F;
    slot_plan[4] = 9'h0FF;
    slot_plan[5] = 9'h100;
    slot_plan[6] = 9'h080;
    slot_plan[7] = 9'h1FF;
    load_slots();
    send_item(pub_item(8'h00, 8'h12));
    send_item(pub_item(8'h7F, 8'h34));
    send_item(pub_item(8'h80, 8'h56));
    send_item(pub_item(8'hFF, 8'h78));
    send_item(disp_item());
    send_item(pub_item(8'h7F, 8'h01));
    send_item(disp_item());
    send_item(disp_item());
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      drain_results(6);
      plan_random_slots();
      if (p == 2) begin
        for (int s = 0; s < NUM_REGS; s++) slot_plan[s] = {1'b1, hot_ids[0]};
      end
      load_slots();
      run_traffic(45);
    end
  endtask

  task automatic test_backpressure();
    drain_results(6);
    plan_random_slots();
    load_slots();
    idle_on  = 1'b0;
    hold_len = 80;
    run_traffic(25);
    drain_results(0);
    run_traffic(15);
    idle_on = 1'b1;
  endtask

  task automatic test_quiet_tail();
    drain_results(6);
    plan_random_slots();
    load_slots();
    idle_on = 1'b0;
    run_traffic(50);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue_no_subscribers();
    test_fanout_and_full_queue();
    test_mixed_slots();
    test_random_phases();
    test_backpressure();
    test_quiet_tail();
    drain_results(20);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
